// ===== rtl/core/svt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svt_pkg: shared types and constants of the Sauvola window threshold
// Datapath operation codes, controller status group, register indexes and
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package svt_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_MAX_HALF  = 12;

  localparam logic [11:0] RST_WIDTH  = 12'd640;
  localparam logic [15:0] RST_HEIGHT = 16'd480;
  localparam logic [3:0]  RST_HALF   = 4'd12;
  localparam logic [7:0]  RST_K      = 8'd128;

  localparam logic MODE_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_HALF   = 2'd2,
    CFG_K      = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_RD_CTR,
    OP_LATCH_PX,
    OP_SWEEP_INIT,
    OP_SWEEP,
    OP_MUL,
    OP_DIFF,
    OP_SQRT,
    OP_DIV,
    OP_KT,
    OP_F,
    OP_RHS,
    OP_CMP,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    logic pend_over;
    logic pend_zero;
    logic border;
    logic sweep_last;
    logic pipe_empty;
    logic iter_zero;
    logic out_free;
  } svt_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/svt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svt_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module svt_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/svt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svt_ctrl: sequencing controller
// Takes input transfers and steps the datapath through line store access,
// window sweep, square root, division, threshold test and result load.
// ----------------------------------------------------------------------------
module svt_ctrl
  import svt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tuser_i,
  output logic             s_tready_o,
  output dp_op_e           op_o,
  input  wire svt_status_t st_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_RD_CTR, ST_LATCH, ST_INIT, ST_SWEEP, ST_DRAIN,
    ST_MUL, ST_DIFF, ST_SQRT, ST_DIV, ST_KT, ST_F, ST_RHS, ST_CMP, ST_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          if (s_tuser_i != MODE_FLUSH) begin
            op_o    = OP_WRITE;
            state_d = ST_CHECK;
          end else if (!st_i.pend_zero) begin
            state_d = ST_RD_CTR;
          end
        end
      end
      ST_CHECK: state_d = st_i.pend_over ? ST_RD_CTR : ST_IDLE;
      ST_RD_CTR: begin
        op_o    = OP_RD_CTR;
        state_d = ST_LATCH;
      end
      ST_LATCH: begin
        op_o    = OP_LATCH_PX;
        state_d = st_i.border ? ST_OUT : ST_INIT;
      end
      ST_INIT: begin
        op_o    = OP_SWEEP_INIT;
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        op_o = OP_SWEEP;
        if (st_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (st_i.pipe_empty) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        op_o    = OP_MUL;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        op_o    = OP_DIFF;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        op_o = OP_SQRT;
        if (st_i.iter_zero) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        op_o = OP_DIV;
        if (st_i.iter_zero) begin
          state_d = ST_KT;
        end
      end
      ST_KT: begin
        op_o    = OP_KT;
        state_d = ST_F;
      end
      ST_F: begin
        op_o    = OP_F;
        state_d = ST_RHS;
      end
      ST_RHS: begin
        op_o    = OP_RHS;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        op_o    = OP_CMP;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (st_i.out_free) begin
          op_o    = OP_OUT;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/svt_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svt_dp: datapath of the Sauvola window threshold
// Configuration registers, line store, raster counters, window accumulator,
// bit-serial square root and divider, threshold test and output register.
// ----------------------------------------------------------------------------
module svt_dp
  import svt_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HALF  = DEF_MAX_HALF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic [23:0] s_tdata_i,
  input  wire dp_op_e      op_i,
  output svt_status_t      st_o,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [23:0]      m_tdata_o,
  output logic             m_tuser_o,
  output logic             m_tlast_o
);

  localparam int Ring    = 2 * MAX_HALF + 2;
  localparam int SlotW   = $clog2(Ring);
  localparam int AddrW   = $clog2(Ring * MAX_WIDTH);
  localparam int ColW    = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HALF + 1);
  localparam int IdxW    = $clog2(2 * MAX_HALF + 1);
  localparam int NMax    = (2 * MAX_HALF + 1) * (2 * MAX_HALF + 1);
  localparam int NW      = $clog2(NMax + 1);
  localparam int SumW    = $clog2(NMax * 255 + 1);
  localparam int SqW     = $clog2(NMax * 65025 + 1);
  localparam int DW      = NW + SqW;
  localparam int RadW    = DW + 32;
  localparam int RW      = (RadW + 1) / 2;
  localparam int CW      = NW + 8;
  localparam int DivW    = (RW > CW + 15) ? RW : CW + 15;
  localparam int LagW    = HW + WW + 1;
  localparam int IterMax = (RW > 16) ? RW : 16;
  localparam int IterW   = $clog2(IterMax);
  localparam int RhsW    = SumW + 25;
  localparam int LhsW    = CW + 24;
  localparam int CmpW    = (RhsW > LhsW) ? RhsW : LhsW;

  function automatic logic [7:0] grey_of(input logic [23:0] px);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(px[7:0]) + 10'(px[15:8]) + 10'(px[23:16]);
    // Multiply by 683/2048; exact for every sum of three bytes.
    prod = 20'(sum) * 20'd683;
    return prod[18:11];
  endfunction

  function automatic logic [AddrW-1:0] addr_of(input logic [SlotW-1:0] slot,
                                               input logic [ColW-1:0] col);
    return AddrW'(slot) * AddrW'(MAX_WIDTH) + AddrW'(col);
  endfunction

  // Configuration.
  logic [11:0] cfg_width_q;
  logic [15:0] cfg_height_q;
  logic [3:0]  cfg_half_q;
  logic [7:0]  cfg_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= RST_WIDTH;
      cfg_height_q <= RST_HEIGHT;
      cfg_half_q   <= RST_HALF;
      cfg_k_q      <= RST_K;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  cfg_width_q  <= cfg_data_i[11:0];
        CFG_HEIGHT: cfg_height_q <= cfg_data_i;
        CFG_HALF:   cfg_half_q   <= cfg_data_i[3:0];
        CFG_K:      cfg_k_q      <= cfg_data_i[7:0];
        default:    cfg_k_q      <= cfg_k_q;
      endcase
    end
  end

  logic [WW-1:0]   w_eff;
  logic [15:0]     ht_eff;
  logic [HW-1:0]   h_eff;
  logic [LagW-1:0] lag;

  always_comb begin
    if (cfg_width_q == 12'd0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_q);
    end
    ht_eff = (cfg_height_q == 16'd0) ? 16'd1 : cfg_height_q;
    h_eff  = (32'(cfg_half_q) > 32'(MAX_HALF)) ? HW'(MAX_HALF) : HW'(cfg_half_q);
    lag    = LagW'(h_eff) * LagW'(w_eff) + LagW'(h_eff);
  end

  // Raster positions of the newest input and of the next result.
  logic [ColW-1:0]  in_col_q, out_col_q;
  logic [15:0]      in_row_q, out_row_q;
  logic [SlotW-1:0] in_slot_q, out_slot_q;
  logic [LagW-1:0]  pend_q;
  logic [WW-1:0]    in_col_inc, out_col_inc;
  logic [16:0]      in_row_inc, out_row_inc;

  assign in_col_inc  = WW'(in_col_q) + WW'(1);
  assign out_col_inc = WW'(out_col_q) + WW'(1);
  assign in_row_inc  = 17'(in_row_q) + 17'd1;
  assign out_row_inc = 17'(out_row_q) + 17'd1;

  logic border, frame_last;
  assign border = (17'(out_row_q) < 17'(h_eff))
               || (17'(out_row_q) + 17'(h_eff) >= 17'(ht_eff))
               || ((WW + 1)'(out_col_q) < (WW + 1)'(h_eff))
               || ((WW + 1)'(out_col_q) + (WW + 1)'(h_eff) >= (WW + 1)'(w_eff));
  assign frame_last = (out_row_q == ht_eff - 16'd1)
                   && (WW'(out_col_q) == w_eff - WW'(1));

  logic m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      pend_q     <= '0;
    end else if (op_i == OP_WRITE) begin
      pend_q <= pend_q + LagW'(1);
      if (in_col_inc >= w_eff) begin
        in_col_q  <= '0;
        in_row_q  <= (in_row_inc >= 17'(ht_eff)) ? 16'd0 : in_row_inc[15:0];
        in_slot_q <= (in_slot_q == SlotW'(Ring - 1)) ? '0 : in_slot_q + SlotW'(1);
      end else begin
        in_col_q <= in_col_inc[ColW-1:0];
      end
    end else if (op_i == OP_OUT) begin
      pend_q <= pend_q - LagW'(1);
      if (out_col_inc >= w_eff) begin
        out_col_q  <= '0;
        out_row_q  <= (out_row_inc >= 17'(ht_eff)) ? 16'd0 : out_row_inc[15:0];
        out_slot_q <= (out_slot_q == SlotW'(Ring - 1)) ? '0 : out_slot_q + SlotW'(1);
      end else begin
        out_col_q <= out_col_inc[ColW-1:0];
      end
    end
  end

  // Window sweep addressing.
  logic [SlotW-1:0] sw_slot_q;
  logic [ColW-1:0]  sw_col_q, sw_col0_q;
  logic [IdxW-1:0]  sw_i_q, sw_j_q, two_h_q;
  logic [SlotW-1:0] slot_start;
  logic [ColW-1:0]  col_start;
  logic [NW-1:0]    n_calc;

  always_comb begin
    if ((SlotW + 1)'(out_slot_q) >= (SlotW + 1)'(h_eff)) begin
      slot_start = SlotW'((SlotW + 1)'(out_slot_q) - (SlotW + 1)'(h_eff));
    end else begin
      slot_start = SlotW'((SlotW + 1)'(out_slot_q) + (SlotW + 1)'(Ring)
                          - (SlotW + 1)'(h_eff));
    end
    col_start = out_col_q - ColW'(h_eff);
    n_calc    = NW'((IdxW + 1)'(h_eff) * 2 + 1) * NW'((IdxW + 1)'(h_eff) * 2 + 1);
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_SWEEP_INIT) begin
      sw_slot_q <= slot_start;
      sw_col_q  <= col_start;
      sw_col0_q <= col_start;
      sw_i_q    <= '0;
      sw_j_q    <= '0;
      two_h_q   <= IdxW'(h_eff) << 1;
    end else if (op_i == OP_SWEEP) begin
      if (sw_i_q == two_h_q) begin
        sw_i_q    <= '0;
        sw_col_q  <= sw_col0_q;
        sw_j_q    <= sw_j_q + IdxW'(1);
        sw_slot_q <= (sw_slot_q == SlotW'(Ring - 1)) ? '0 : sw_slot_q + SlotW'(1);
      end else begin
        sw_i_q   <= sw_i_q + IdxW'(1);
        sw_col_q <= sw_col_q + ColW'(1);
      end
    end
  end

  // Line store of original pixels.
  logic [23:0]      rdata;
  logic [AddrW-1:0] raddr;
  logic             re;

  assign re    = (op_i == OP_RD_CTR) || (op_i == OP_SWEEP);
  assign raddr = (op_i == OP_RD_CTR) ? addr_of(out_slot_q, out_col_q)
                                     : addr_of(sw_slot_q, sw_col_q);

  svt_ram #(
    .Width (24),
    .Depth (Ring * MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (op_i == OP_WRITE),
    .waddr_i (addr_of(in_slot_q, in_col_q)),
    .wdata_i (s_tdata_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Accumulator pipeline: read data, grey value, sums.
  logic v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= (op_i == OP_SWEEP);
      v2_q <= v1_q;
    end
  end

  logic [7:0]      grey_q, gc_q;
  logic [23:0]     px_q;
  logic [SumW-1:0] s_q;
  logic [SqW-1:0]  q_q;
  logic [NW-1:0]   n_q;
  logic [CW-1:0]   c_q;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      grey_q <= grey_of(rdata);
    end
    if (op_i == OP_LATCH_PX) begin
      px_q <= rdata;
      gc_q <= grey_of(rdata);
    end
    if (op_i == OP_SWEEP_INIT) begin
      s_q <= '0;
      q_q <= '0;
      n_q <= n_calc;
      c_q <= (CW'(n_calc) << 8) - CW'(n_calc);
    end else if (v2_q) begin
      s_q <= s_q + SumW'(grey_q);
      q_q <= q_q + SqW'(16'(grey_q) * 16'(grey_q));
    end
  end

  // Variance, square root, division and threshold test.
  logic [DW-1:0]     nq_q, ss_q, d;
  logic [CW-1:0]     gn_q;
  logic [2*RW-1:0]   rad_q;
  logic [RW+1:0]     rem_q, rem_sh, trial, rem_nxt;
  logic [RW-1:0]     root_q, root_nxt;
  logic              sq_ge, dv_ge;
  logic [DivW-1:0]   drem_q, dsh_q;
  logic [15:0]       quo_q;
  logic [IterW-1:0]  iter_q;
  logic [24:0]       kt_q, f_q;
  logic [RhsW-1:0]   rhs_q;
  logic [CmpW-1:0]   lhs_ext;
  logic              white_q;

  assign d        = nq_q - ss_q;
  assign rem_sh   = {rem_q[RW-1:0], rad_q[2*RW-1 -: 2]};
  assign trial    = {root_q, 2'b01};
  assign sq_ge    = rem_sh >= trial;
  assign rem_nxt  = sq_ge ? rem_sh - trial : rem_sh;
  assign root_nxt = {root_q[RW-2:0], sq_ge};
  assign dv_ge    = drem_q >= dsh_q;
  assign lhs_ext  = CmpW'({gn_q, 24'h000000});

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_MUL: begin
        nq_q <= DW'(n_q) * DW'(q_q);
        ss_q <= DW'(s_q) * DW'(s_q);
        gn_q <= CW'(gc_q) * CW'(n_q);
      end
      OP_DIFF: begin
        rad_q  <= (2 * RW)'({d, 32'h00000000});
        rem_q  <= '0;
        root_q <= '0;
        iter_q <= IterW'(RW - 1);
      end
      OP_SQRT: begin
        rem_q  <= rem_nxt;
        root_q <= root_nxt;
        rad_q  <= rad_q << 2;
        if (iter_q == '0) begin
          // The root is floor(sqrt(D) * 2^16); divide it by 255*n next.
          drem_q <= DivW'(root_nxt);
          dsh_q  <= DivW'(c_q) << 15;
          quo_q  <= '0;
          iter_q <= IterW'(15);
        end else begin
          iter_q <= iter_q - IterW'(1);
        end
      end
      OP_DIV: begin
        drem_q <= dv_ge ? drem_q - dsh_q : drem_q;
        quo_q  <= {quo_q[14:0], dv_ge};
        dsh_q  <= dsh_q >> 1;
        if (iter_q != '0) begin
          iter_q <= iter_q - IterW'(1);
        end
      end
      OP_KT:  kt_q <= 25'(cfg_k_q) * (25'h0010000 - 25'(quo_q));
      OP_F:   f_q <= 25'h1000000 - kt_q;
      OP_RHS: rhs_q <= RhsW'(s_q) * RhsW'(f_q);
      OP_CMP: white_q <= lhs_ext > CmpW'(rhs_q);
      default: begin
        white_q <= white_q;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (op_i == OP_OUT) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_OUT) begin
      m_tdata_o <= border ? px_q : {24{white_q}};
      m_tuser_o <= border;
      m_tlast_o <= frame_last;
    end
  end

  assign m_tvalid_o = m_valid_q;

  assign st_o.pend_over  = pend_q > lag;
  assign st_o.pend_zero  = (pend_q == '0);
  assign st_o.border     = border;
  assign st_o.sweep_last = (sw_i_q == two_h_q) && (sw_j_q == two_h_q);
  assign st_o.pipe_empty = !v1_q && !v2_q;
  assign st_o.iter_zero  = (iter_q == '0);
  assign st_o.out_free   = !m_valid_q || m_tready_i;

endmodule
`default_nettype wire

// ===== rtl/core/sauvola_window_threshold.sv =====
`default_nettype none
// Order of work: a border pixel is offered once the pixel transfer or flush that releases
// it has been taken; an interior pixel needs one line store read per window pixel, a read
// pipeline through the line store read register, the grey value and the sums, a 34-step
// square root and a 16-step divider with default parameters. No new transfer is accepted
// until a released pixel has been loaded into the output register. Reset: asynchronous,
// active low; the line store is not cleared.
// ----------------------------------------------------------------------------
// sauvola_window_threshold: streaming Sauvola binarizer
// Raster RGB pixels in, thresholded or pass-through pixels out, delayed by
// h rows plus h pixels; flush items drain the tail of a frame.
// ----------------------------------------------------------------------------
module sauvola_window_threshold
  import svt_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HALF  = DEF_MAX_HALF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // red, green, blue
  input  wire logic        s_axis_tuser_i,  // mode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,  // out_red, out_green, out_blue
  output logic             m_axis_tuser_o,  // is_border
  output logic             m_axis_tlast_o
);

  dp_op_e      op;
  svt_status_t st;

  svt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tuser_i  (s_axis_tuser_i),
    .s_tready_o (s_axis_tready_o),
    .op_o       (op),
    .st_i       (st)
  );

  svt_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tdata_i  (s_axis_tdata_i),
    .op_i       (op),
    .st_o       (st),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule
`default_nettype wire
